@@ design/dmss_pkg.sv @@
// Shared types, widths and helpers for the diagonal segment scorer.
// Used by dmss_table and diagonal_max_segment_score; depends on nothing.
`default_nettype none

package dmss_pkg;

	localparam int ALPHABET_SIZE = 64;
	localparam int MAX_RUN       = 4096;

	// Fixed field widths of the stream items
	localparam int LETTER_W = 6;
	localparam int ENTRY_W  = 16;
	localparam int TAG_W    = 13;
	localparam int BEST_W   = 27;
	localparam int START_W  = 12;
	localparam int LEN_W    = 13;

	localparam int TABLE_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
	localparam int TABLE_AW    = $clog2(TABLE_DEPTH);

	// Run counters must hold MAX_RUN itself
	localparam int POS_W = $clog2(MAX_RUN + 1);
	// Signed suffix: MAX_RUN entries of at most 2^(ENTRY_W-1)-1 each, plus sign
	localparam int SUFFIX_W = $clog2(MAX_RUN) + ENTRY_W;
	localparam int RUNBEST_W = SUFFIX_W - 1;

	localparam int IN_FIELDS_W  = 2 * LETTER_W + ENTRY_W + TAG_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = BEST_W + START_W + LEN_W + TAG_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_PAIR = 1'b1;

	// Table access request, one per accepted beat
	typedef struct packed {
		logic                wr_en;
		logic                rd_en;
		logic [LETTER_W-1:0] row;
		logic [LETTER_W-1:0] col;
	} tbl_req_t;

	// Result item, last field in the lowest bits
	typedef struct packed {
		logic               run_overflow;
		logic [TAG_W-1:0]   result_tag;
		logic [LEN_W-1:0]   best_length;
		logic [START_W-1:0] best_start;
		logic [BEST_W-1:0]  best_score;
	} result_t;

	function automatic logic in_alphabet(logic [LETTER_W-1:0] row, logic [LETTER_W-1:0] col);
		return (int'(row) < ALPHABET_SIZE) && (int'(col) < ALPHABET_SIZE);
	endfunction

	function automatic logic [TABLE_AW-1:0] table_addr(logic [LETTER_W-1:0] row,
		logic [LETTER_W-1:0] col);
		int a;
		a = int'(row) * ALPHABET_SIZE + int'(col);
		return a[TABLE_AW-1:0];
	endfunction

endpackage

`default_nettype wire

@@ design/diagonal_max_segment_score.sv @@
// Best ungapped segment along one diagonal: table lookup, then suffix/best update.
// A last pair's result is registered in the result queue, whose head drives m_tdata.
// Throughput: one beat per cycle unless input stalls; the table read and the run update each take one stage.
// A two-entry result queue lets input flow on; input stalls only while it is full
// and the beat in the update stage carries a result.
// Reset (arst_n low) clears run state and the queue; the score table is not cleared.
`default_nettype none

module diagonal_max_segment_score (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// [5:0] query_letter, [11:6] target_letter, [27:12] entry_value,
	// [40:28] diagonal_tag, rest zero
	input  wire logic [dmss_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  wire logic                                 s_tuser,  // operation
	input  wire logic                                 s_tlast,  // last_pair
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// [26:0] best_score, [38:27] best_start, [51:39] best_length,
	// [64:52] result_tag, [65] run_overflow, rest zero
	output logic [dmss_pkg::OUT_TDATA_W-1:0]          m_tdata
);

	localparam int SW = dmss_pkg::SUFFIX_W;
	localparam int BW = dmss_pkg::RUNBEST_W;
	localparam int PW = dmss_pkg::POS_W;

	// input beat unpacking
	logic [dmss_pkg::LETTER_W-1:0]      in_query;
	logic [dmss_pkg::LETTER_W-1:0]      in_target;
	logic signed [dmss_pkg::ENTRY_W-1:0] in_entry;
	logic [dmss_pkg::TAG_W-1:0]         in_tag;
	logic                               in_fire;
	dmss_pkg::tbl_req_t                 tbl_req;
	logic signed [dmss_pkg::ENTRY_W-1:0] score_s1;

	assign in_query  = s_tdata[dmss_pkg::LETTER_W-1:0];
	assign in_target = s_tdata[2*dmss_pkg::LETTER_W-1:dmss_pkg::LETTER_W];
	assign in_entry  = s_tdata[2*dmss_pkg::LETTER_W+dmss_pkg::ENTRY_W-1:2*dmss_pkg::LETTER_W];
	assign in_tag    = s_tdata[dmss_pkg::IN_FIELDS_W-1:
		dmss_pkg::IN_FIELDS_W-dmss_pkg::TAG_W];
	assign in_fire   = s_tvalid && s_tready;

	// loads write at accept, so a pair on the next beat already reads the new entry
	always_comb begin
		tbl_req.wr_en = in_fire && (s_tuser == dmss_pkg::OP_LOAD);
		tbl_req.rd_en = in_fire && (s_tuser == dmss_pkg::OP_PAIR);
		tbl_req.row   = in_query;
		tbl_req.col   = in_target;
	end

	dmss_table u_table (
		.clk   (clk),
		.req   (tbl_req),
		.wdata (in_entry),
		.score (score_s1)
	);

	// stage 1 control and payload
	logic                       valid_s1;
	logic                       op_s1;
	logic                       last_s1;
	logic [dmss_pkg::TAG_W-1:0] tag_s1;

	// run state
	logic signed [SW-1:0] suffix_q;
	logic [BW-1:0]        best_q;
	logic [PW-1:0]        suffix_len_q;
	logic [PW-1:0]        suffix_start_q;
	logic [PW-1:0]        best_start_q;
	logic [PW-1:0]        best_len_q;
	logic [PW-1:0]        position_q;
	logic                 ovf_q;

	logic signed [SW-1:0] suffix_n;
	logic [BW-1:0]        best_n;
	logic [PW-1:0]        suffix_len_n;
	logic [PW-1:0]        suffix_start_n;
	logic [PW-1:0]        best_start_n;
	logic [PW-1:0]        best_len_n;
	logic [PW-1:0]        position_n;
	logic                 ovf_n;
	logic signed [SW-1:0] sum_s1;
	logic                 res_s1;
	logic                 adv_s1;
	dmss_pkg::result_t    res_item;

	// result queue
	dmss_pkg::result_t head_q;
	dmss_pkg::result_t skid_q;
	logic [1:0]        cnt_q;
	logic              full;
	logic              push;
	logic              pop;

	assign full     = (cnt_q == 2'd2);
	assign res_s1   = valid_s1 && (op_s1 == dmss_pkg::OP_PAIR) && last_s1;
	assign adv_s1   = valid_s1 && !(res_s1 && full);
	assign s_tready = !(res_s1 && full);
	assign sum_s1   = suffix_q + SW'(score_s1);

	always_comb begin
		suffix_n       = suffix_q;
		best_n         = best_q;
		suffix_len_n   = suffix_len_q;
		suffix_start_n = suffix_start_q;
		best_start_n   = best_start_q;
		best_len_n     = best_len_q;
		position_n     = position_q;
		ovf_n          = ovf_q;
		if (op_s1 == dmss_pkg::OP_PAIR) begin
			if (position_q >= PW'(dmss_pkg::MAX_RUN)) begin
				ovf_n = 1'b1;
			end else begin
				suffix_n = sum_s1;
				// strict compare: ties keep the earlier best
				if (sum_s1 > $signed({1'b0, best_q})) begin
					best_n       = sum_s1[BW-1:0];
					best_start_n = suffix_start_q;
					suffix_len_n = suffix_len_q + 1'b1;
					best_len_n   = suffix_len_q + 1'b1;
				end else if (sum_s1 > 0) begin
					suffix_len_n = suffix_len_q + 1'b1;
				end else begin
					suffix_n       = '0;
					suffix_start_n = position_q + 1'b1;
					suffix_len_n   = '0;
				end
				position_n = position_q + 1'b1;
			end
		end
		res_item.best_score   = dmss_pkg::BEST_W'(best_n);
		res_item.best_start   = dmss_pkg::START_W'(best_start_n);
		res_item.best_length  = dmss_pkg::LEN_W'(best_len_n);
		res_item.result_tag   = tag_s1;
		res_item.run_overflow = ovf_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= s_tuser;
			last_s1 <= s_tlast;
			tag_s1  <= in_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			suffix_q       <= '0;
			best_q         <= '0;
			suffix_len_q   <= '0;
			suffix_start_q <= '0;
			best_start_q   <= '0;
			best_len_q     <= '0;
			position_q     <= '0;
			ovf_q          <= 1'b0;
		end else if (adv_s1) begin
			if (res_s1) begin
				// emit and clear the run
				suffix_q       <= '0;
				best_q         <= '0;
				suffix_len_q   <= '0;
				suffix_start_q <= '0;
				best_start_q   <= '0;
				best_len_q     <= '0;
				position_q     <= '0;
				ovf_q          <= 1'b0;
			end else begin
				suffix_q       <= suffix_n;
				best_q         <= best_n;
				suffix_len_q   <= suffix_len_n;
				suffix_start_q <= suffix_start_n;
				best_start_q   <= best_start_n;
				best_len_q     <= best_len_n;
				position_q     <= position_n;
				ovf_q          <= ovf_n;
			end
		end
	end

	assign push = adv_s1 && res_s1;
	assign pop  = m_tvalid && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push && !pop) begin
			cnt_q <= cnt_q + 2'd1;
		end else if (pop && !push) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push && pop) begin
			if (cnt_q == 2'd1) begin
				head_q <= res_item;
			end else begin
				head_q <= skid_q;
				skid_q <= res_item;
			end
		end else if (push) begin
			if (cnt_q == 2'd0) begin
				head_q <= res_item;
			end else begin
				skid_q <= res_item;
			end
		end else if (pop && full) begin
			head_q <= skid_q;
		end
	end

	assign m_tvalid = (cnt_q != 2'd0);
	assign m_tdata  = {{(dmss_pkg::OUT_TDATA_W-dmss_pkg::OUT_FIELDS_W){1'b0}}, head_q};

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

	a_suffix_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		!suffix_q[SW-1])
		else $error("stored suffix score negative");

	a_best_len: assert property (@(posedge clk) disable iff (!arst_n)
		best_len_q <= position_q)
		else $error("best length exceeds position");

	a_clear_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (position_q == '0) && (best_q == '0) && !ovf_q)
		else $error("run state not cleared after result");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> full && valid_s1)
		else $error("input stalled without full queue");

endmodule

`default_nettype wire

@@ design/dmss_table.sv @@
// Substitution score table: one synchronous memory, one access per cycle.
// Depends on dmss_pkg for widths, the request struct and address helpers.
`default_nettype none

module dmss_table (
	input  wire logic                                clk,
	input  wire dmss_pkg::tbl_req_t                  req,
	input  wire logic signed [dmss_pkg::ENTRY_W-1:0] wdata,
	output logic signed [dmss_pkg::ENTRY_W-1:0]      score
);

	logic signed [dmss_pkg::ENTRY_W-1:0] mem [dmss_pkg::TABLE_DEPTH];
	logic signed [dmss_pkg::ENTRY_W-1:0] rdata_q;
	logic                                alpha_q;
	logic [dmss_pkg::TABLE_AW-1:0]       addr;
	logic                                alpha;

	assign addr  = dmss_pkg::table_addr(req.row, req.col);
	assign alpha = dmss_pkg::in_alphabet(req.row, req.col);

	always_ff @(posedge clk) begin
		if (req.wr_en && alpha) begin
			mem[addr] <= wdata;
		end
		if (req.rd_en) begin
			rdata_q <= mem[addr];
			alpha_q <= alpha;
		end
	end

	// letters outside the alphabet score zero
	assign score = alpha_q ? rdata_q : '0;

endmodule

`default_nettype wire
